@@ src/gac_pkg.sv @@
package gac_pkg;

    // Opcodes carried on s_tuser
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_BLEND = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_TEXT_COLOR  = 3'd0;
    localparam logic [2:0] REG_DEST_X      = 3'd1;
    localparam logic [2:0] REG_DEST_Y      = 3'd2;
    localparam logic [2:0] REG_IMAGE_WIDTH = 3'd3;
    localparam logic [2:0] REG_FRAME_WIDTH = 3'd4;

    // Command address covers the largest supported frame store
    localparam int CMD_ADDR_W = 22;

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_BLEND,
        CMD_READ
    } cmd_kind_t;

    // One classified command passed from front to back
    typedef struct packed {
        cmd_kind_t             kind;
        logic [CMD_ADDR_W-1:0] addr;
        logic                  hit;    // address inside the store
        logic [7:0]            alpha;  // blend strength
        logic                  flag;   // content flag snapshot for reads
    } cmd_t;

    // Exact floor(x / 255) for any x up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

@@ src/gac_ram.sv @@
module gac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/gac_queue.sv @@
module gac_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  gac_pkg::cmd_t push_cmd,
    output logic          ready,
    output logic          valid,
    output gac_pkg::cmd_t head_cmd,
    input  logic          pop
);
    import gac_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign ready    = count_reg != CNT_W'(DEPTH);
    assign valid    = count_reg != '0;
    assign head_cmd = slot_reg[rd_ptr_reg];

    // Store pushed commands
    always_ff @(posedge aclk) begin
        if (push && ready) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push && ready) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && valid) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push && ready, pop && valid})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("command queue over capacity");

endmodule

@@ src/gac_front.sv @@
module gac_front #(
    parameter int FRAME_PIXELS    = 65536,
    parameter int MAX_FRAME_WIDTH = 1024
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [1:0]    in_opcode,
    input  logic [7:0]    in_coverage,
    input  logic          in_image_start,
    input  logic [15:0]   in_read_index,
    input  logic          init_done,
    input  logic [7:0]    transparency,
    input  logic [9:0]    dest_x,
    input  logic [9:0]    dest_y,
    input  logic [10:0]   image_width,
    input  logic [10:0]   frame_width,
    output logic          q_push,
    output gac_pkg::cmd_t q_cmd,
    input  logic          q_ready
);
    import gac_pkg::*;

    typedef enum logic {
        F_IDLE,
        F_CALC
    } state_t;

    state_t      state_reg;
    logic [1:0]  op_reg;
    logic [7:0]  cov_reg;
    logic [15:0] ridx_reg;
    logic [10:0] col_reg;
    logic [9:0]  row_reg;
    logic [10:0] col_used_reg;
    logic [9:0]  row_used_reg;
    logic        flag_reg;

    logic        accept;
    logic [10:0] iw;
    logic [10:0] fw;
    logic [10:0] col_eff;
    logic [9:0]  row_eff;
    logic [11:0] col_inc;
    logic        col_wrap;
    logic [10:0] y_sum;
    logic [11:0] x_sum;
    logic [21:0] prod;
    logic [22:0] pos;
    logic [15:0] aprod;
    logic [7:0]  alpha;
    logic        blend_hit;
    logic        read_hit;
    logic        need_push;
    cmd_t        cmd;

    // Zero width acts as one, oversize widths saturate
    function automatic logic [10:0] clamp_w(input logic [10:0] w);
        if (w == 11'd0) begin
            return 11'd1;
        end
        if ({2'b0, w} > 13'(MAX_FRAME_WIDTH)) begin
            return 11'(MAX_FRAME_WIDTH);
        end
        return w;
    endfunction

    assign iw       = clamp_w(image_width);
    assign fw       = clamp_w(frame_width);
    assign s_tready = (state_reg == F_IDLE) && init_done;
    assign accept   = s_tvalid && s_tready;

    // Image position for this beat, with start resetting both counters
    assign col_eff  = in_image_start ? '0 : col_reg;
    assign row_eff  = in_image_start ? '0 : row_reg;
    assign col_inc  = {1'b0, col_eff} + 12'd1;
    assign col_wrap = col_inc >= {1'b0, iw};

    // Frame address and blend strength
    assign y_sum     = {1'b0, dest_y} + {1'b0, row_used_reg};
    assign x_sum     = {2'b0, dest_x} + {1'b0, col_used_reg};
    assign prod      = y_sum * fw;
    assign pos       = {1'b0, prod} + {11'b0, x_sum};
    assign aprod     = cov_reg * (8'hFF - transparency);
    assign alpha     = aprod[15:8];
    assign blend_hit = (alpha != 8'd0) && (pos < 23'(FRAME_PIXELS));
    assign read_hit  = {7'b0, ridx_reg} < 23'(FRAME_PIXELS);

    // Build the command for the back end
    always_comb begin
        cmd.kind  = CMD_CLEAR;
        cmd.addr  = '0;
        cmd.hit   = 1'b0;
        cmd.alpha = alpha;
        cmd.flag  = flag_reg;
        need_push = 1'b0;
        case (op_reg)
            OP_CLEAR: begin
                need_push = 1'b1;
            end
            OP_BLEND: begin
                cmd.kind  = CMD_BLEND;
                cmd.addr  = pos[CMD_ADDR_W-1:0];
                cmd.hit   = blend_hit;
                need_push = blend_hit;
            end
            OP_READ: begin
                cmd.kind  = CMD_READ;
                cmd.addr  = {6'b0, ridx_reg};
                cmd.hit   = read_hit;
                need_push = 1'b1;
            end
            default: begin
                need_push = 1'b0;
            end
        endcase
    end

    assign q_cmd  = cmd;
    assign q_push = (state_reg == F_CALC) && need_push;

    // Accept a beat, track position and content, then hand off
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            flag_reg  <= 1'b0;
        end else begin
            case (state_reg)
                F_IDLE: begin
                    if (accept) begin
                        op_reg    <= in_opcode;
                        cov_reg   <= in_coverage;
                        ridx_reg  <= in_read_index;
                        state_reg <= F_CALC;
                        case (in_opcode)
                            OP_BLEND: begin
                                col_used_reg <= col_eff;
                                row_used_reg <= row_eff;
                                col_reg      <= col_wrap ? '0 : col_inc[10:0];
                                row_reg      <= col_wrap ? row_eff + 10'd1 : row_eff;
                                flag_reg     <= 1'b1;
                            end
                            OP_CLEAR: begin
                                flag_reg <= 1'b0;
                            end
                            default: begin
                                flag_reg <= flag_reg;
                            end
                        endcase
                    end
                end
                F_CALC: begin
                    if (!need_push || q_ready) begin
                        state_reg <= F_IDLE;
                    end
                end
                default: begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    a_col_in_image: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (in_opcode == OP_BLEND) |=> col_reg < iw)
        else $error("image column left the image row");

    a_blend_alpha: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push && (q_cmd.kind == CMD_BLEND) |-> q_cmd.alpha != 8'd0)
        else $error("blend command with zero alpha");

endmodule

@@ src/gac_back.sv @@
module gac_back #(
    parameter int FRAME_PIXELS = 65536
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    input  gac_pkg::cmd_t q_cmd,
    output logic          q_pop,
    input  logic [23:0]   color_rgb,
    output logic          init_done,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [31:0]   m_pixel,
    output logic          m_flag
);
    import gac_pkg::*;

    localparam int AW = $clog2(FRAME_PIXELS);

    typedef enum logic [2:0] {
        B_SWEEP,
        B_IDLE,
        B_MIX,
        B_WRITE,
        B_RESP
    } state_t;

    state_t      state_reg;
    logic [AW-1:0] sweep_reg;
    logic        init_done_reg;
    cmd_t        cmd_reg;
    logic [15:0] sr_reg;
    logic [15:0] sg_reg;
    logic [15:0] sb_reg;
    logic [15:0] sa_reg;
    logic        direct_reg;
    logic        out_valid_reg;
    logic [31:0] out_pixel_reg;
    logic        out_flag_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [31:0]   ram_rdata;
    logic [7:0]    src_r;
    logic [7:0]    src_g;
    logic [7:0]    src_b;
    logic [7:0]    inv;
    logic [15:0]   sum_r;
    logic [15:0]   sum_g;
    logic [15:0]   sum_b;
    logic [15:0]   sum_a;
    logic [7:0]    new_a;
    logic [31:0]   new_word;

    // Take the next command; a read waits for a free output register
    assign q_pop = (state_reg == B_IDLE) && q_valid &&
                   ((q_cmd.kind != CMD_READ) || !out_valid_reg);

    assign src_r = color_rgb[23:16];
    assign src_g = color_rgb[15:8];
    assign src_b = color_rgb[7:0];
    assign inv   = 8'hFF - cmd_reg.alpha;

    // Weighted channel sums from the stored pixel
    assign sum_r = cmd_reg.alpha * src_r + inv * ram_rdata[7:0];
    assign sum_g = cmd_reg.alpha * src_g + inv * ram_rdata[15:8];
    assign sum_b = cmd_reg.alpha * src_b + inv * ram_rdata[23:16];
    assign sum_a = inv * ram_rdata[31:24];

    // Finish the blend: an empty pixel takes the color outright
    assign new_a    = cmd_reg.alpha + div255(sa_reg);
    assign new_word = direct_reg ?
                      {cmd_reg.alpha, src_b, src_g, src_r} :
                      {new_a, div255(sb_reg), div255(sg_reg), div255(sr_reg)};

    // Sweep writes zeros, blend writes the mixed pixel
    assign ram_we    = (state_reg == B_SWEEP) || (state_reg == B_WRITE);
    assign ram_waddr = (state_reg == B_SWEEP) ? sweep_reg : cmd_reg.addr[AW-1:0];
    assign ram_wdata = (state_reg == B_SWEEP) ? '0 : new_word;

    gac_ram #(
        .WIDTH (32),
        .DEPTH (FRAME_PIXELS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (q_pop),
        .raddr (q_cmd.addr[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Sequence sweeps, read-modify-writes and read responses
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_SWEEP;
            sweep_reg     <= '0;
            init_done_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_SWEEP: begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == AW'(FRAME_PIXELS - 1)) begin
                        init_done_reg <= 1'b1;
                        state_reg     <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (q_pop) begin
                        cmd_reg <= q_cmd;
                        case (q_cmd.kind)
                            CMD_CLEAR: begin
                                sweep_reg <= '0;
                                state_reg <= B_SWEEP;
                            end
                            CMD_BLEND: state_reg <= B_MIX;
                            CMD_READ:  state_reg <= B_RESP;
                            default:   state_reg <= B_IDLE;
                        endcase
                    end
                end
                B_MIX: begin
                    sr_reg     <= sum_r;
                    sg_reg     <= sum_g;
                    sb_reg     <= sum_b;
                    sa_reg     <= sum_a;
                    direct_reg <= ram_rdata[31:24] == 8'd0;
                    state_reg  <= B_WRITE;
                end
                B_WRITE: begin
                    state_reg <= B_IDLE;
                end
                B_RESP: begin
                    out_pixel_reg <= cmd_reg.hit ? ram_rdata : '0;
                    out_flag_reg  <= cmd_reg.flag;
                    out_valid_reg <= 1'b1;
                    state_reg     <= B_IDLE;
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign init_done = init_done_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_pixel   = out_pixel_reg;
    assign m_flag    = out_flag_reg;

    a_resp_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == B_RESP))
        else $error("result raised outside a read response");

    a_write_after_mix: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_WRITE |-> $past(state_reg == B_MIX))
        else $error("blend write without a mix step");

    a_init_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        init_done_reg |=> init_done_reg)
        else $error("init done dropped after the reset sweep");

endmodule

@@ src/glyph_alpha_compositor.sv @@
// Channel  | Handshake          | Payload
// s_       | s_tvalid/s_tready  | tuser opcode; tdata coverage, image_start, read_index
// m_       | m_tvalid/m_tready  | tdata pixel_rgba, drawn
// cfg_     | cfg_wr_en          | cfg_addr register index, cfg_wdata value
//
// The front takes one beat at a time (accept, then address and alpha, then hand-off).
// The back sets the sustained rate: a blend is a read-modify-write (read, mix,
// write) on the frame store's single write port; a read ends in the output beat.
// A clear sweeps the store at one word a cycle, writing zeros over all FRAME_PIXELS words.
// After reset the same sweep runs before s_tready rises.
// A two-entry command queue and the output register let either side stall alone.
module glyph_alpha_compositor #(
    parameter int FRAME_PIXELS    = 65536,
    parameter int MAX_FRAME_WIDTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [7:0] coverage, [8] image_start, [24:9] read_index
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] pixel_rgba, [32] drawn
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);
    import gac_pkg::*;

    logic [31:0] text_color_reg;
    logic [9:0]  dest_x_reg;
    logic [9:0]  dest_y_reg;
    logic [10:0] image_width_reg;
    logic [10:0] frame_width_reg;

    logic        q_push;
    cmd_t        push_cmd;
    logic        q_ready;
    logic        q_valid;
    cmd_t        head_cmd;
    logic        q_pop;
    logic        init_done;
    logic [31:0] pixel;
    logic        flag;

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_color_reg  <= '0;
            dest_x_reg      <= '0;
            dest_y_reg      <= '0;
            image_width_reg <= 11'd1;
            frame_width_reg <= 11'd256;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_TEXT_COLOR:  text_color_reg  <= cfg_wdata;
                REG_DEST_X:      dest_x_reg      <= cfg_wdata[9:0];
                REG_DEST_Y:      dest_y_reg      <= cfg_wdata[9:0];
                REG_IMAGE_WIDTH: image_width_reg <= cfg_wdata[10:0];
                REG_FRAME_WIDTH: frame_width_reg <= cfg_wdata[10:0];
                default: begin
                    text_color_reg <= text_color_reg;
                end
            endcase
        end
    end

    gac_front #(
        .FRAME_PIXELS    (FRAME_PIXELS),
        .MAX_FRAME_WIDTH (MAX_FRAME_WIDTH)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .in_opcode      (s_tuser),
        .in_coverage    (s_tdata[7:0]),
        .in_image_start (s_tdata[8]),
        .in_read_index  (s_tdata[24:9]),
        .init_done      (init_done),
        .transparency   (text_color_reg[7:0]),
        .dest_x         (dest_x_reg),
        .dest_y         (dest_y_reg),
        .image_width    (image_width_reg),
        .frame_width    (frame_width_reg),
        .q_push         (q_push),
        .q_cmd          (push_cmd),
        .q_ready        (q_ready)
    );

    gac_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .ready    (q_ready),
        .valid    (q_valid),
        .head_cmd (head_cmd),
        .pop      (q_pop)
    );

    gac_back #(
        .FRAME_PIXELS (FRAME_PIXELS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_cmd     (head_cmd),
        .q_pop     (q_pop),
        .color_rgb (text_color_reg[31:8]),
        .init_done (init_done),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_pixel   (pixel),
        .m_flag    (flag)
    );

    assign m_tdata = {7'b0, flag, pixel};

endmodule
